/* design/dq_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the circular deque
// no dependencies

package dq_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } dq_mode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dq_status_e;

  localparam int unsigned FieldBits = 32;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } dq_cmd_t;

  // datapath occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } dq_flags_t;

endpackage

/* design/dq_req_if.sv */
`timescale 1ns / 1ps
// request channel: operation and push word with valid/ready
// depends on dq_pkg

interface dq_req_if;
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  dq_mode_e                    mode;
  logic signed [FieldBits-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

/* design/dq_rsp_if.sv */
`timescale 1ns / 1ps
// response channel: status and popped word with valid/ready
// depends on dq_pkg

interface dq_rsp_if;
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  dq_status_e                  status;
  logic signed [FieldBits-1:0] pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

/* design/dq_ctrl.sv */
`timescale 1ns / 1ps
// sequencing of one item: accept, execute, hold the result
// depends on dq_pkg

module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dq_pkg::dq_cmd_t cmd_o
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o    = in_ready_q;
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_valid_i & in_ready_q;
  assign cmd_o.exec    = (state_q == S_EXEC);

endmodule

/* design/dq_datapath.sv */
`timescale 1ns / 1ps
// ring store, head and tail indices, result registers
// depends on dq_pkg

module dq_datapath #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dq_pkg::dq_cmd_t                     cmd_i,
  input  dq_pkg::dq_mode_e                    mode_i,
  input  logic signed [dq_pkg::FieldBits-1:0] push_value_i,
  output dq_pkg::dq_status_e                  status_o,
  output logic signed [dq_pkg::FieldBits-1:0] pop_value_o,
  output dq_pkg::dq_flags_t                   flags_o
);
  import dq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  logic [WORD_BITS-1:0] mem [DEPTH];

  dq_mode_e             mode_q;
  logic [WORD_BITS-1:0] word_q;
  logic [IdxW-1:0]      head_q, head_d;
  logic [IdxW-1:0]      tail_q, tail_d;
  logic                 empty_q, empty_d;
  dq_status_e           status_q, status_d;
  logic                 pop_ok_q, pop_ok_d;
  logic [WORD_BITS-1:0] rdata_q;

  logic                 we, re;
  logic [IdxW-1:0]      waddr, raddr;
  logic                 full;
  logic                 is_push, is_front;

  function automatic logic [IdxW-1:0] step_fwd(input logic [IdxW-1:0] i);
    step_fwd = (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] step_back(input logic [IdxW-1:0] i);
    step_back = (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  assign full     = !empty_q && (step_fwd(tail_q) == head_q);
  assign is_push  = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_PUSH_REAR);
  assign is_front = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_POP_FRONT);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    status_d = ST_DONE;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = '0;
    raddr    = is_front ? head_q : tail_q;
    if (is_push) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else if (empty_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
        we      = 1'b1;
      end else if (is_front) begin
        head_d = step_back(head_q);
        waddr  = head_d;
        we     = 1'b1;
      end else begin
        tail_d = step_fwd(tail_q);
        waddr  = tail_d;
        we     = 1'b1;
      end
    end else begin
      if (empty_q) begin
        status_d = ST_UNDERFLOW;
      end else begin
        re       = 1'b1;
        pop_ok_d = 1'b1;
        // last word leaves: back to the reset position
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else if (is_front) begin
          head_d = step_fwd(head_q);
        end else begin
          tail_d = step_back(tail_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      word_q <= WORD_BITS'($unsigned(push_value_i));
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= word_q;
    end
    if (cmd_i.exec && re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign status_o      = status_q;
  assign pop_value_o   = pop_ok_q ? FieldBits'(rdata_q) : '0;
  assign flags_o.empty = empty_q;
  assign flags_o.full  = full;

endmodule

/* design/circular_deque.sv */
`timescale 1ns / 1ps
// top level of the circular deque: controller and datapath
// depends on dq_pkg, dq_req_if, dq_rsp_if, dq_ctrl, dq_datapath

// Double-ended queue of DEPTH words of WORD_BITS bits held in a ring memory.
// Each request item pushes at the front or rear, or pops from the front or
// rear; exactly one response item follows, with status done, overflow (push
// to a full queue, nothing changes) or underflow (pop from an empty queue),
// and the popped word zero-extended or truncated to 32 bits (zero unless a
// pop succeeds). One item is in flight at a time: it is taken, executed
// against the memory in the next cycle, and its response is presented in
// the cycle after that and held until the response channel takes it; the
// read data are registered. The queue is empty after reset and needs no
// clearing pass.

module circular_deque #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  dq_cmd_t   cmd;
  dq_flags_t flags;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (req_i.mode),
    .push_value_i (req_i.push_value),
    .status_o     (rsp_o.status),
    .pop_value_o  (rsp_o.pop_value),
    .flags_o      (flags)
  );

  // a pending response blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a response is pending");

  // every accepted request yields a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> ##2 rsp_o.valid)
    else $error("response missing after accepted request");

  // failed operations return a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_DONE) |-> (rsp_o.pop_value == '0))
    else $error("non-zero word on failed operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags.empty && flags.full))
    else $error("queue flagged empty and full at once");

endmodule
